@@ rtl/sut_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted unique table package
// Shared types and codes for the sorted table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sut_pkg;

	// Wide enough for every entry index and count over the supported depths.
	localparam int PTR_W = 9;

	localparam logic [2:0] CMD_INSERT     = 3'd0;
	localparam logic [2:0] CMD_REMOVE_VAL = 3'd1;
	localparam logic [2:0] CMD_REMOVE_POS = 3'd2;
	localparam logic [2:0] CMD_REPLACE    = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;

	localparam logic [2:0] STS_DONE   = 3'd0;
	localparam logic [2:0] STS_DUP    = 3'd1;
	localparam logic [2:0] STS_MISS   = 3'd2;
	localparam logic [2:0] STS_FULL   = 3'd3;
	localparam logic [2:0] STS_BADPOS = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} ctl_state_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_UP,
		SH_DOWN
	} shift_t;

	typedef struct packed {
		logic               en;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] key;
	} cmp_bus_t;

	typedef struct packed {
		shift_t             mode;
		logic [PTR_W-1:0]   lo;
		logic [PTR_W-1:0]   hi;
		logic               ld;
		logic [PTR_W-1:0]   ld_at;
		logic signed [31:0] ld_data;
	} cell_op_t;

	typedef struct packed {
		logic eq_a;
		logic eq_b;
		logic lt;
	} cell_flag_t;

endpackage

`default_nettype wire

@@ rtl/sut_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted unique table cell
// Holds one entry, compares it against the command operands and moves it
// to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sut_cell #(
	parameter int IDX = 0
) (
	input  wire                    clk,
	input  wire sut_pkg::cmp_bus_t cmp,
	input  wire sut_pkg::cell_op_t op,
	input  wire logic signed [31:0] left_data,
	input  wire logic signed [31:0] right_data,
	output logic signed [31:0]     data,
	output sut_pkg::cell_flag_t    flags
);

	localparam logic [sut_pkg::PTR_W-1:0] MY_IDX = sut_pkg::PTR_W'(IDX);

	logic signed [31:0]  data_q;
	sut_pkg::cell_flag_t flags_q;
	logic                in_range;

	assign in_range = (MY_IDX >= op.lo) && (MY_IDX < op.hi);

	always_ff @(posedge clk) begin
		if (cmp.en) begin
			flags_q.eq_a <= (data_q == cmp.a);
			flags_q.eq_b <= (data_q == cmp.b);
			flags_q.lt   <= (data_q < cmp.key);
		end
		if (op.ld && (op.ld_at == MY_IDX)) begin
			data_q <= op.ld_data;
		end else if (in_range && (op.mode == sut_pkg::SH_UP)) begin
			data_q <= left_data;
		end else if (in_range && (op.mode == sut_pkg::SH_DOWN)) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign flags = flags_q;

endmodule

`default_nettype wire

@@ rtl/sut_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted unique table control
// Takes a command beat, drives the cell compares, decodes the cell flags
// into a shift plan and returns the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sut_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [71:0]         s_axis_tdata,
	input  wire logic [2:0]          s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	output logic [15:0]              m_axis_tdata,
	output logic [2:0]               m_axis_tuser,
	output sut_pkg::cmp_bus_t        cmp,
	output sut_pkg::cell_op_t        op,
	input  wire logic [DEPTH-1:0]    eq_a,
	input  wire logic [DEPTH-1:0]    eq_b,
	input  wire logic [DEPTH-1:0]    lt
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = sut_pkg::PTR_W;

	sut_pkg::ctl_state_t state_q, state_d;
	logic [2:0]          cmd_q;
	logic signed [31:0]  val_q, nval_q;
	logic [3:0]          pos_q;
	logic [CW-1:0]       fill_q;
	logic                m_valid_q;
	logic [2:0]          m_status_q;
	logic [3:0]          m_where_q;
	logic [4:0]          m_held_q;

	logic                accept, go, out_free;
	logic [PW-1:0]       fill_w, idx_a, edge_enc, rank, pos_w;
	logic [DEPTH-1:0]    valid, ea, eb, lv;
	logic                hit_a, hit_b, hit_e;
	logic [2:0]          status;
	logic [PW-1:0]       where_w, fill_nx;
	sut_pkg::cell_op_t   plan;

	assign out_free = !m_valid_q || m_axis_tready;
	assign fill_w   = PW'(fill_q);
	assign pos_w    = PW'(pos_q);

	always_comb begin
		idx_a    = '0;
		edge_enc = '0;
		hit_e    = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			valid[i] = PW'(i) < fill_w;
			ea[i]    = eq_a[i] & valid[i];
			eb[i]    = eq_b[i] & valid[i];
			lv[i]    = lt[i] & valid[i];
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (ea[i]) begin
				idx_a = idx_a | PW'(i);
			end
			if (lv[i] && ((i == DEPTH - 1) || !lv[(i + 1) % DEPTH])) begin
				edge_enc = edge_enc | PW'(i);
				hit_e    = 1'b1;
			end
		end
		hit_a = |ea;
		hit_b = |eb;
		rank  = hit_e ? edge_enc + PW'(1) : '0;
	end

	always_comb begin
		status       = sut_pkg::STS_DONE;
		where_w      = '0;
		fill_nx      = fill_w;
		plan.mode    = sut_pkg::SH_HOLD;
		plan.lo      = '0;
		plan.hi      = '0;
		plan.ld      = 1'b0;
		plan.ld_at   = '0;
		plan.ld_data = val_q;
		case (cmd_q)
			sut_pkg::CMD_INSERT: begin
				if (hit_a) begin
					status = sut_pkg::STS_DUP;
				end else if (fill_w == PW'(DEPTH)) begin
					status = sut_pkg::STS_FULL;
				end else begin
					plan.mode  = sut_pkg::SH_UP;
					plan.lo    = rank + PW'(1);
					plan.hi    = fill_w + PW'(1);
					plan.ld    = 1'b1;
					plan.ld_at = rank;
					where_w    = rank;
					fill_nx    = fill_w + PW'(1);
				end
			end
			sut_pkg::CMD_REMOVE_VAL: begin
				if (!hit_a) begin
					status = sut_pkg::STS_MISS;
				end else begin
					plan.mode = sut_pkg::SH_DOWN;
					plan.lo   = idx_a;
					plan.hi   = fill_w - PW'(1);
					where_w   = idx_a;
					fill_nx   = fill_w - PW'(1);
				end
			end
			sut_pkg::CMD_REMOVE_POS: begin
				if (pos_w >= fill_w) begin
					status = sut_pkg::STS_BADPOS;
				end else begin
					plan.mode = sut_pkg::SH_DOWN;
					plan.lo   = pos_w;
					plan.hi   = fill_w - PW'(1);
					where_w   = pos_w;
					fill_nx   = fill_w - PW'(1);
				end
			end
			sut_pkg::CMD_REPLACE: begin
				plan.ld_data = nval_q;
				if (!hit_a) begin
					status = sut_pkg::STS_MISS;
				end else if (hit_b) begin
					status = sut_pkg::STS_DUP;
				end else if (idx_a < rank) begin
					plan.mode  = sut_pkg::SH_DOWN;
					plan.lo    = idx_a;
					plan.hi    = rank - PW'(1);
					plan.ld    = 1'b1;
					plan.ld_at = rank - PW'(1);
					where_w    = rank - PW'(1);
				end else begin
					plan.mode  = sut_pkg::SH_UP;
					plan.lo    = rank + PW'(1);
					plan.hi    = idx_a + PW'(1);
					plan.ld    = 1'b1;
					plan.ld_at = rank;
					where_w    = rank;
				end
			end
			sut_pkg::CMD_SEARCH: begin
				if (!hit_a) begin
					status = sut_pkg::STS_MISS;
				end else begin
					where_w = idx_a;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		accept        = 1'b0;
		go            = 1'b0;
		cmp.en        = 1'b0;
		cmp.a         = val_q;
		cmp.b         = nval_q;
		cmp.key       = (cmd_q == sut_pkg::CMD_REPLACE) ? nval_q : val_q;
		case (state_q)
			sut_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					accept  = 1'b1;
					state_d = sut_pkg::ST_CMP;
				end
			end
			sut_pkg::ST_CMP: begin
				cmp.en  = 1'b1;
				state_d = sut_pkg::ST_APPLY;
			end
			sut_pkg::ST_APPLY: begin
				if (out_free) begin
					go      = 1'b1;
					state_d = sut_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sut_pkg::ST_IDLE;
			end
		endcase
		op = plan;
		if (!go) begin
			op.mode = sut_pkg::SH_HOLD;
			op.ld   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sut_pkg::ST_IDLE;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go) begin
				fill_q    <= CW'(fill_nx);
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_axis_tuser;
			val_q  <= s_axis_tdata[31:0];
			nval_q <= s_axis_tdata[63:32];
			pos_q  <= s_axis_tdata[67:64];
		end
		if (go) begin
			m_status_q <= status;
			m_where_q  <= (status == sut_pkg::STS_DONE) ? where_w[3:0] : 4'd0;
			m_held_q   <= fill_nx[4:0];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {7'd0, m_held_q, m_where_q};

endmodule

`default_nettype wire

@@ rtl/sorted_unique_table.sv @@
// ----------------------------------------------------------------------------
// Sorted unique table
// Up to DEPTH distinct signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Each command goes through these steps from its input beat to its result
// beat: the beat is captured, every cell compares its entry with the
// operands, and the control decodes the cell flags while the cells in the
// planned range shift toward their neighbors at once. A new command beat
// is taken as soon as the previous one has moved its result into the output
// register, so no new command is taken while another is still in flight.
// The result beat waits while the output is stalled. Entries beyond the
// count are never read, so the table needs no clearing after reset.
`default_nettype none

module sorted_unique_table #(
	parameter int DEPTH = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	// value [31:0], new_value [63:32], position [67:64], zero [71:68]
	input  wire logic [71:0]  s_axis_tdata,
	// command [2:0]
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	// where [3:0], entries_held [8:4], zero [15:9]
	output logic [15:0]       m_axis_tdata,
	// status [2:0]
	output logic [2:0]        m_axis_tuser
);

	sut_pkg::cmp_bus_t   cmp;
	sut_pkg::cell_op_t   op;
	sut_pkg::cell_flag_t flags [DEPTH];
	logic signed [31:0]  data  [DEPTH];
	logic [DEPTH-1:0]    eq_a, eq_b, lt;

	sut_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cmp          (cmp),
		.op           (op),
		.eq_a         (eq_a),
		.eq_b         (eq_b),
		.lt           (lt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_d, right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = data[i+1];
		end

		sut_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.cmp       (cmp),
			.op        (op),
			.left_data (left_d),
			.right_data(right_d),
			.data      (data[i]),
			.flags     (flags[i])
		);

		assign eq_a[i] = flags[i].eq_a;
		assign eq_b[i] = flags[i].eq_b;
		assign lt[i]   = flags[i].lt;
	end

endmodule

`default_nettype wire

@@ tb/sorted_unique_table_tb.sv @@
// ----------------------------------------------------------------------------
// Sorted unique table testbench
// Sends insert, remove, remove-at-position, replace, search and spare
// commands as input beats. A table model inside the bench computes the
// status, position and count of every accepted command. Each result beat is
// checked field by field against the oldest pending prediction. Directed
// corner cases run first, then a long random mix that fills and drains the
// table. Both sides of the block stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int STALL_PCT = 19;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [2:0] status;
		logic [3:0] where;
		logic [4:0] held;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	logic               steady = 1'b0;
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	outcome_t           expected_results[$];
	logic signed [31:0] model_entries[DEPTH];
	int                 model_fill = 0;

	sorted_unique_table #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int index_of(logic signed [31:0] v);
		for (int i = 0; i < model_fill; i++)
			if (model_entries[i] == v)
				return i;
		return model_fill;
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i + 1 < model_fill; i++)
			model_entries[i] = model_entries[i + 1];
		model_fill--;
	endfunction

	function automatic int place_sorted(logic signed [31:0] v);
		int p;
		p = 0;
		for (int i = 0; i < model_fill; i++)
			if (model_entries[i] < v)
				p++;
		for (int i = model_fill; i > p; i--)
			model_entries[i] = model_entries[i - 1];
		model_entries[p] = v;
		model_fill++;
		return p;
	endfunction

	function automatic outcome_t table_outcome(logic [2:0] cmd, logic signed [31:0] v,
			logic signed [31:0] nv, logic [3:0] pos);
		outcome_t o;
		int idx;
		o.status = sut_pkg::STS_DONE;
		idx = 0;
		case (cmd)
			sut_pkg::CMD_INSERT: begin
				if (index_of(v) < model_fill)
					o.status = sut_pkg::STS_DUP;
				else if (model_fill >= DEPTH)
					o.status = sut_pkg::STS_FULL;
				else
					idx = place_sorted(v);
			end
			sut_pkg::CMD_REMOVE_VAL: begin
				idx = index_of(v);
				if (idx >= model_fill)
					o.status = sut_pkg::STS_MISS;
				else
					drop_entry(idx);
			end
			sut_pkg::CMD_REMOVE_POS: begin
				if (int'(pos) >= model_fill) begin
					o.status = sut_pkg::STS_BADPOS;
				end else begin
					idx = pos;
					drop_entry(idx);
				end
			end
			sut_pkg::CMD_REPLACE: begin
				idx = index_of(v);
				if (idx >= model_fill) begin
					o.status = sut_pkg::STS_MISS;
				end else if (index_of(nv) < model_fill) begin
					o.status = sut_pkg::STS_DUP;
				end else begin
					drop_entry(idx);
					idx = place_sorted(nv);
				end
			end
			sut_pkg::CMD_SEARCH: begin
				idx = index_of(v);
				if (idx >= model_fill)
					o.status = sut_pkg::STS_MISS;
			end
			default: begin
			end
		endcase
		o.where = (o.status == sut_pkg::STS_DONE) ? 4'(idx) : 4'd0;
		o.held = 5'(model_fill);
		return o;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_cmd(input logic [2:0] cmd, input logic signed [31:0] v,
			input logic signed [31:0] nv = 32'sd0, input logic [3:0] pos = 4'd0);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, pos, nv, v};
		s_axis_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_results.push_back(table_outcome(cmd, v, nv, pos));
	endtask

	function automatic logic signed [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && model_fill > 0)
			return model_entries[$urandom_range(model_fill - 1)];
		if (roll < 70) begin
			case ($urandom_range(3))
				0: return INT_MIN;
				1: return INT_MAX;
				default: return $signed(32'($urandom_range(8))) - 32'sd4;
			endcase
		end
		return $urandom;
	endfunction

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing expected, status %0d",
					m_axis_tuser));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d",
						m_axis_tuser, want.status));
				if (m_axis_tdata[3:0] !== want.where)
					flag_mismatch($sformatf("where %0d, expected %0d",
						m_axis_tdata[3:0], want.where));
				if (m_axis_tdata[8:4] !== want.held)
					flag_mismatch($sformatf("entries_held %0d, expected %0d",
						m_axis_tdata[8:4], want.held));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_unique_table_tb NOT OK");
			$finish;
		end
	end

	task automatic test_empty_table();
		send_cmd(sut_pkg::CMD_SEARCH, 32'sd0);
		send_cmd(sut_pkg::CMD_REMOVE_VAL, 32'sd0);
		send_cmd(sut_pkg::CMD_REMOVE_POS, 32'sd0, 32'sd0, 4'd0);
	endtask

	task automatic test_extremes();
		send_cmd(sut_pkg::CMD_INSERT, INT_MAX);
		send_cmd(sut_pkg::CMD_INSERT, INT_MIN);
		send_cmd(sut_pkg::CMD_INSERT, 32'sd0);
		send_cmd(sut_pkg::CMD_INSERT, -32'sd1);
		send_cmd(sut_pkg::CMD_INSERT, 32'sd1);
		send_cmd(sut_pkg::CMD_INSERT, 32'sd0);
		send_cmd(sut_pkg::CMD_SEARCH, INT_MAX);
	endtask

	task automatic test_error_cases();
		send_cmd(sut_pkg::CMD_REPLACE, 32'sd77, 32'sd5);
		send_cmd(sut_pkg::CMD_REPLACE, 32'sd1, INT_MIN);
		send_cmd(sut_pkg::CMD_REPLACE, -32'sd1, -32'sd1);
		send_cmd(sut_pkg::CMD_REPLACE, -32'sd1, INT_MAX - 32'sd1);
		send_cmd(sut_pkg::CMD_REMOVE_POS, 32'sd0, 32'sd0, 4'd15);
		send_cmd(sut_pkg::CMD_REMOVE_VAL, INT_MIN);
	endtask

	task automatic test_spare_commands();
		for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
			send_cmd(3'(c), $urandom, $urandom, 4'($urandom));
	endtask

	task automatic test_fill_to_full();
		while (model_fill < DEPTH)
			send_cmd(sut_pkg::CMD_INSERT, $urandom);
		send_cmd(sut_pkg::CMD_INSERT, INT_MIN);
		send_cmd(sut_pkg::CMD_INSERT, model_entries[DEPTH - 1]);
		send_cmd(sut_pkg::CMD_REMOVE_POS, 32'sd0, 32'sd0, 4'd15);
	endtask

	task automatic test_random_mix();
		int counted;
		int roll;
		logic grow;
		logic [2:0] cmd;
		logic signed [31:0] v;
		logic signed [31:0] nv;
		logic [3:0] pos;
		counted = 0;
		grow = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			steady = (counted >= 500 && counted < 800);
			if (model_fill == DEPTH)
				grow = 1'b0;
			else if (model_fill == 0)
				grow = 1'b1;
			else if ($urandom_range(99) < 3)
				grow = ~grow;
			roll = $urandom_range(99);
			if (roll < 4)
				cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			else if (grow)
				cmd = roll < 50 ? sut_pkg::CMD_INSERT :
					roll < 65 ? sut_pkg::CMD_REPLACE :
					roll < 80 ? sut_pkg::CMD_SEARCH :
					roll < 90 ? sut_pkg::CMD_REMOVE_VAL : sut_pkg::CMD_REMOVE_POS;
			else
				cmd = roll < 18 ? sut_pkg::CMD_INSERT :
					roll < 28 ? sut_pkg::CMD_REPLACE :
					roll < 40 ? sut_pkg::CMD_SEARCH :
					roll < 70 ? sut_pkg::CMD_REMOVE_VAL : sut_pkg::CMD_REMOVE_POS;
			v = pick_value();
			roll = $urandom_range(99);
			if (roll < 10)
				nv = v;
			else if (roll < 35 && model_fill > 0)
				nv = model_entries[$urandom_range(model_fill - 1)];
			else
				nv = pick_value();
			if (model_fill > 0 && $urandom_range(99) < 70)
				pos = 4'($urandom_range(model_fill - 1));
			else
				pos = 4'($urandom_range(15));
			send_cmd(cmd, v, nv, pos);
			if (cmd < CMD_SPARE_LO)
				counted++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extremes();
		test_error_cases();
		test_spare_commands();
		test_fill_to_full();
		test_random_mix();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_unique_table_tb OK");
		else
			$display("sorted_unique_table_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/sut_pkg.sv
rtl/sut_cell.sv
rtl/sut_ctrl.sv
rtl/sorted_unique_table.sv
tb/sorted_unique_table_tb.sv
